// ===== hdl/bglu_pkg.sv =====
// Shared types and constants for the binary GCD/LCM unit.
// No dependencies; used by the interfaces, the core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bglu_pkg;

    // Width of every operand field and of the GCD and LCM result fields on the item channels
    localparam int FIELD_BITS = 64;

    // Sequencer states of the core
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_STRIP  = 7'b0000010,
        ST_NORMX  = 7'b0000100,
        ST_REDUCE = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_MUL    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    // Core status seen by the top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

endpackage

`default_nettype wire

// ===== hdl/bglu_in_if.sv =====
// Input item channel: valid/ready handshake with two operands.
// Depends on bglu_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface bglu_in_if;
    logic                             valid;
    logic                             ready;
    logic [bglu_pkg::FIELD_BITS-1:0] operand_a;
    logic [bglu_pkg::FIELD_BITS-1:0] operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

`default_nettype wire

// ===== hdl/bglu_out_if.sv =====
// Result item channel: valid/ready handshake with GCD, LCM and overflow flag.
// Depends on bglu_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface bglu_out_if;
    logic                             valid;
    logic                             ready;
    logic [bglu_pkg::FIELD_BITS-1:0] gcd_value;
    logic [bglu_pkg::FIELD_BITS-1:0] lcm_value;
    logic                             lcm_overflow;

    modport source (output valid, output gcd_value, output lcm_value,
                    output lcm_overflow, input ready);
    modport sink   (input valid, input gcd_value, input lcm_value,
                    input lcm_overflow, output ready);
endinterface

`default_nettype wire

// ===== hdl/bglu_core.sv =====
// Iterative GCD/LCM datapath: one shared adder/subtractor under a sequencer.
// Binary GCD, restoring division a/g, then shift-add multiply (a/g)*b.
// Depends on bglu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bglu_core #(
    parameter int WORD_BITS = 64
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire                      i_take,
    input  wire  [WORD_BITS-1:0]     i_operand_a,
    input  wire  [WORD_BITS-1:0]     i_operand_b,
    output bglu_pkg::t_core_stat     o_stat,
    output logic [WORD_BITS-1:0]     o_gcd,
    output logic [WORD_BITS-1:0]     o_lcm,
    output logic                     o_ovf
);

    localparam int SH_BITS  = $clog2(WORD_BITS + 1);
    localparam int CNT_BITS = $clog2(WORD_BITS);
    localparam int ADD_BITS = WORD_BITS + 2;

    bglu_pkg::t_state r_state, n_state;

    logic [WORD_BITS-1:0]   r_a, n_a;
    logic [WORD_BITS-1:0]   r_b, n_b;
    logic [WORD_BITS-1:0]   r_x, n_x;     // gcd x, then dividend/quotient, then multiplier
    logic [WORD_BITS-1:0]   r_y, n_y;     // gcd y, then remainder
    logic [WORD_BITS-1:0]   r_g, n_g;
    logic [2*WORD_BITS-1:0] r_prod, n_prod;
    logic [SH_BITS-1:0]     r_shared, n_shared;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;

    // shared adder: sum = op1 + op2 + cin
    logic [ADD_BITS-1:0] add_op1, add_op2, add_sum;
    logic                add_cin;
    logic                borrow;

    assign add_sum = add_op1 + add_op2 + ADD_BITS'(add_cin);
    assign borrow  = add_sum[ADD_BITS-1];

    always_comb begin
        add_op1 = {2'b00, r_y};
        add_op2 = ~{2'b00, r_x};
        add_cin = 1'b1;
        case (r_state)
            bglu_pkg::ST_DIV: begin
                add_op1 = {1'b0, r_y, r_x[WORD_BITS-1]};
                add_op2 = ~{2'b00, r_g};
                add_cin = 1'b1;
            end
            bglu_pkg::ST_MUL: begin
                add_op1 = {2'b00, r_prod[2*WORD_BITS-1:WORD_BITS]};
                add_op2 = r_x[0] ? {2'b00, r_b} : '0;
                add_cin = 1'b0;
            end
            default: begin
                add_op1 = {2'b00, r_y};
                add_op2 = ~{2'b00, r_x};
                add_cin = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_x      = r_x;
        n_y      = r_y;
        n_g      = r_g;
        n_prod   = r_prod;
        n_shared = r_shared;
        n_cnt    = r_cnt;
        case (r_state)
            bglu_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_a      = i_operand_a;
                    n_b      = i_operand_b;
                    n_x      = i_operand_a;
                    n_y      = i_operand_b;
                    n_shared = '0;
                    n_prod   = '0;
                    if (i_operand_a == '0) begin
                        n_g     = i_operand_b;
                        n_state = bglu_pkg::ST_DONE;
                    end else if (i_operand_b == '0) begin
                        n_g     = i_operand_a;
                        n_state = bglu_pkg::ST_DONE;
                    end else begin
                        n_state = bglu_pkg::ST_STRIP;
                    end
                end
            end
            bglu_pkg::ST_STRIP: begin
                if (!(r_x[0] | r_y[0])) begin
                    n_x      = r_x >> 1;
                    n_y      = r_y >> 1;
                    n_shared = r_shared + SH_BITS'(1);
                end else begin
                    n_state = bglu_pkg::ST_NORMX;
                end
            end
            bglu_pkg::ST_NORMX: begin
                if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else begin
                    n_state = bglu_pkg::ST_REDUCE;
                end
            end
            bglu_pkg::ST_REDUCE: begin
                if (r_y == '0) begin
                    n_g     = r_x << r_shared;
                    n_x     = r_a;
                    n_y     = '0;
                    n_cnt   = '0;
                    n_state = bglu_pkg::ST_DIV;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (borrow) begin
                    // y < x: swap, subtract on the next cycle
                    n_x = r_y;
                    n_y = r_x;
                end else begin
                    n_y = add_sum[WORD_BITS-1:0];
                end
            end
            bglu_pkg::ST_DIV: begin
                if (!borrow) begin
                    n_y = add_sum[WORD_BITS-1:0];
                end else begin
                    n_y = {r_y[WORD_BITS-2:0], r_x[WORD_BITS-1]};
                end
                n_x   = {r_x[WORD_BITS-2:0], ~borrow};
                n_cnt = r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(WORD_BITS - 1)) begin
                    n_cnt   = '0;
                    n_prod  = '0;
                    n_state = bglu_pkg::ST_MUL;
                end
            end
            bglu_pkg::ST_MUL: begin
                n_prod = {add_sum[WORD_BITS:0], r_prod[WORD_BITS-1:1]};
                n_x    = r_x >> 1;
                n_cnt  = r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(WORD_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = bglu_pkg::ST_DONE;
                end
            end
            bglu_pkg::ST_DONE: begin
                if (i_take) begin
                    n_state = bglu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bglu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bglu_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_x      <= n_x;
        r_y      <= n_y;
        r_g      <= n_g;
        r_prod   <= n_prod;
        r_shared <= n_shared;
    end

    assign o_stat = {(r_state == bglu_pkg::ST_IDLE), (r_state == bglu_pkg::ST_DONE)};
    assign o_gcd  = r_g;
    assign o_lcm  = r_prod[WORD_BITS-1:0];
    assign o_ovf  = |r_prod[2*WORD_BITS-1:WORD_BITS];

`ifndef SYNTHESIS
    // the reduction loop only ever sees an odd x
    a_reduce_x_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bglu_pkg::ST_REDUCE) |-> r_x[0])
        else $error("x even in reduce");

    // the divisor is never zero
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bglu_pkg::ST_DIV) |-> (r_g != '0))
        else $error("zero divisor");

    // remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bglu_pkg::ST_DIV) |-> (r_y < r_g))
        else $error("remainder out of range");

    // a finished result is held until the top level takes it
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.done && !i_take) |=> (o_stat.done && $stable(r_prod) && $stable(r_g)))
        else $error("result dropped before take");
`endif

endmodule

`default_nettype wire

// ===== hdl/binary_gcd_lcm_unit_top.sv =====
// Binary GCD/LCM unit, one item at a time through an iterative core.
// When an operand is zero the core goes straight to its result; otherwise it runs
// the GCD shift, swap and subtract steps, then WORD_BITS divide and WORD_BITS multiply
// steps. A new item is accepted only while the core is idle; the next item is accepted
// while a result waits in the output register.
// Reset: synchronous active-low i_rst_n clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module binary_gcd_lcm_unit_top #(
    parameter int WORD_BITS = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    bglu_in_if.sink      i_in,
    bglu_out_if.source   o_out
);

    bglu_pkg::t_core_stat core_stat;
    logic [WORD_BITS-1:0] core_gcd;
    logic [WORD_BITS-1:0] core_lcm;
    logic                 core_ovf;
    logic                 start;
    logic                 take;

    logic                              r_out_valid;
    logic [bglu_pkg::FIELD_BITS-1:0]  r_gcd;
    logic [bglu_pkg::FIELD_BITS-1:0]  r_lcm;
    logic                              r_ovf;

    assign i_in.ready = core_stat.idle;
    assign start      = i_in.valid && core_stat.idle;
    // output register is free when empty or being drained this cycle
    assign take       = core_stat.done && (!r_out_valid || o_out.ready);

    bglu_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_take      (take),
        .i_operand_a (i_in.operand_a[WORD_BITS-1:0]),
        .i_operand_b (i_in.operand_b[WORD_BITS-1:0]),
        .o_stat      (core_stat),
        .o_gcd       (core_gcd),
        .o_lcm       (core_lcm),
        .o_ovf       (core_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_gcd <= bglu_pkg::FIELD_BITS'(core_gcd);
            r_lcm <= bglu_pkg::FIELD_BITS'(core_lcm);
            r_ovf <= core_ovf;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.gcd_value    = r_gcd;
    assign o_out.lcm_value    = r_lcm;
    assign o_out.lcm_overflow = r_ovf;

endmodule

`default_nettype wire
